// File: sv/ncpt_pkg.sv
`timescale 1ns / 1ps

package ncpt_pkg;

    localparam int CB = 21;
    localparam int PACK_W = 3 * CB;
    localparam int CW = CB + 1;
    localparam int DFW = CB + 2;
    localparam int VW = CB + 3;
    localparam int RRW = 2 * CW;
    localparam int SW = 2 * VW;
    localparam int RW = VW;
    localparam int NW = VW + 15;
    localparam int QB = 15;
    localparam int BW = VW + 3;
    localparam int DEPTH_W = 23;
    localparam int NRM_W = 16;

    localparam logic signed [NRM_W-1:0] NRM_POS = 16'sd16384;
    localparam logic signed [NRM_W-1:0] NRM_NEG = -16'sd16384;
    localparam logic [QB-1:0] ONE_Q14 = 15'd16384;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 23'h7FFFFF;

    localparam logic [1:0] MODE_BB = 2'd0;
    localparam logic [1:0] MODE_SS = 2'd1;
    localparam logic [1:0] MODE_BS = 2'd2;

    typedef logic signed [CB-1:0] crd_t;
    typedef logic signed [CW-1:0] cw_t;
    typedef logic signed [DFW-1:0] dfw_t;
    typedef logic signed [VW-1:0] comp_t;

    typedef struct packed {
        logic hit;
        logic norm;
        logic sub_d;
        logic neg;
        logic signed [BW-1:0] base;
        logic [2:0][NRM_W-1:0] fn;
        logic [2:0][VW-1:0] v;
    } ncpt_side_t;

    function automatic logic [CW-1:0] abs_cw(cw_t x);
        abs_cw = x[CW-1] ? CW'(-x) : CW'(x);
    endfunction

    function automatic logic [DFW-1:0] abs_dfw(dfw_t x);
        abs_dfw = x[DFW-1] ? DFW'(-x) : DFW'(x);
    endfunction

    function automatic logic [VW-1:0] abs_comp(comp_t x);
        abs_comp = x[VW-1] ? VW'(-x) : VW'(x);
    endfunction

endpackage

// File: sv/ncpt_front.sv
`timescale 1ns / 1ps

module ncpt_front import ncpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic              kind_a,
    input  logic              kind_b,
    input  logic [PACK_W-1:0] pos_a,
    input  logic [PACK_W-1:0] offset_a,
    input  logic [PACK_W-1:0] extent_a,
    input  logic [PACK_W-1:0] pos_b,
    input  logic [PACK_W-1:0] offset_b,
    input  logic [PACK_W-1:0] extent_b,
    output logic              out_valid,
    output ncpt_side_t        out_side,
    output logic [SW-1:0]     out_sq
);

    // stage 1
    logic v1_reg, ka1_reg, kb1_reg;
    cw_t  ca1_reg [3], cb1_reg [3], ca1_next [3], cb1_next [3];
    crd_t ea1_reg [3], eb1_reg [3], ea1_next [3], eb1_next [3];

    // stage 2
    logic       v2_reg, swap2_reg, swap2_next;
    logic [1:0] mode2_reg, mode2_next;
    dfw_t dif2_reg [3], lo2_reg [3], hi2_reg [3], fc2_reg [3];
    dfw_t dif2_next [3], lo2_next [3], hi2_next [3], fc2_next [3];
    cw_t  hsum2_reg [3], sc2_reg [3], hsum2_next [3], sc2_next [3];
    crd_t r2_reg, r2_next;
    cw_t  rs2_reg, rs2_next;

    // stage 3
    logic       v3_reg, swap3_reg;
    logic [1:0] mode3_reg;
    comp_t ov3_reg [3], vv3_reg [3], ma3_reg [3], mb3_reg [3];
    comp_t ov3_next [3], vv3_next [3], ma3_next [3], mb3_next [3];
    dfw_t  dif3_reg [3], fc3_reg [3];
    crd_t  r3_reg;
    cw_t   rs3_reg;
    logic [RRW-1:0] rsq3_reg, rrq3_reg, rsq3_next, rrq3_next;

    // stage 4
    logic       v4_reg, swap4_reg;
    logic [1:0] mode4_reg;
    logic [SW-1:0] sqv4_reg [3], sqf4_reg [3], sqv4_next [3], sqf4_next [3];
    comp_t mo4_reg, mo4_next, bbdep4_reg, bbdep4_next;
    logic  hitbb4_reg, hitbb4_next, bbpos4_reg, bbpos4_next;
    logic [1:0] ax4_reg, ax4_next;
    comp_t vv4_reg [3];
    dfw_t  fc4_reg [3];
    crd_t  r4_reg;
    cw_t   rs4_reg;
    logic [RRW-1:0] rsq4_reg, rrq4_reg;

    // stage 5
    logic          v5_reg;
    ncpt_side_t    side5_reg, side5_next;
    logic [SW-1:0] sq5_reg, sq5_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ca1_next[i] = cw_t'(crd_t'(pos_a[i*CB +: CB])) + cw_t'(crd_t'(offset_a[i*CB +: CB]));
            cb1_next[i] = cw_t'(crd_t'(pos_b[i*CB +: CB])) + cw_t'(crd_t'(offset_b[i*CB +: CB]));
            ea1_next[i] = crd_t'(extent_a[i*CB +: CB]);
            eb1_next[i] = crd_t'(extent_b[i*CB +: CB]);
        end
    end

    always_comb
    begin
        cw_t bc, sc;
        crd_t bh;
        swap2_next = ka1_reg & ~kb1_reg;
        if (!ka1_reg && !kb1_reg)
            mode2_next = MODE_BB;
        else if (ka1_reg && kb1_reg)
            mode2_next = MODE_SS;
        else
            mode2_next = MODE_BS;
        for (int i = 0; i < 3; i++)
        begin
            bc = swap2_next ? cb1_reg[i] : ca1_reg[i];
            bh = swap2_next ? eb1_reg[i] : ea1_reg[i];
            sc = swap2_next ? ca1_reg[i] : cb1_reg[i];
            dif2_next[i]  = dfw_t'(cb1_reg[i]) - dfw_t'(ca1_reg[i]);
            hsum2_next[i] = cw_t'(ea1_reg[i]) + cw_t'(eb1_reg[i]);
            lo2_next[i]   = dfw_t'(bc) - dfw_t'(bh);
            hi2_next[i]   = dfw_t'(bc) + dfw_t'(bh);
            sc2_next[i]   = sc;
            fc2_next[i]   = dfw_t'(sc) - dfw_t'(bc);
        end
        r2_next  = swap2_next ? ea1_reg[0] : eb1_reg[0];
        rs2_next = cw_t'(ea1_reg[0]) + cw_t'(eb1_reg[0]);
    end

    always_comb
    begin
        dfw_t scx, mn, cl;
        logic [CW-1:0] ar;
        for (int i = 0; i < 3; i++)
        begin
            ov3_next[i] = comp_t'(hsum2_reg[i]) - comp_t'(signed'({1'b0, abs_dfw(dif2_reg[i])}));
            scx = dfw_t'(sc2_reg[i]);
            mn  = (scx < hi2_reg[i]) ? scx : hi2_reg[i];
            cl  = (lo2_reg[i] > mn) ? lo2_reg[i] : mn;
            vv3_next[i] = (mode2_reg == MODE_SS) ? comp_t'(dif2_reg[i])
                                                 : comp_t'(scx) - comp_t'(cl);
            ma3_next[i] = comp_t'(scx) - comp_t'(lo2_reg[i]);
            mb3_next[i] = comp_t'(hi2_reg[i]) - comp_t'(scx);
        end
        ar = abs_cw(cw_t'(r2_reg));
        rsq3_next = RRW'(abs_cw(rs2_reg)) * RRW'(abs_cw(rs2_reg));
        rrq3_next = RRW'(ar) * RRW'(ar);
    end

    always_comb
    begin
        logic [VW-1:0] av;
        logic [DFW-1:0] af;
        comp_t mo;
        for (int i = 0; i < 3; i++)
        begin
            av = abs_comp(vv3_reg[i]);
            af = abs_dfw(fc3_reg[i]);
            sqv4_next[i] = SW'(av) * SW'(av);
            sqf4_next[i] = SW'(af) * SW'(af);
        end
        mo = ma3_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            mo = (ma3_reg[i] < mo) ? ma3_reg[i] : mo;
            mo = (mb3_reg[i] < mo) ? mb3_reg[i] : mo;
        end
        mo4_next = mo;
        hitbb4_next = (ov3_reg[0] > 0) && (ov3_reg[1] > 0) && (ov3_reg[2] > 0);
        priority if (ov3_reg[0] < ov3_reg[1] && ov3_reg[0] < ov3_reg[2])
            ax4_next = 2'd0;
        else if (ov3_reg[1] < ov3_reg[2])
            ax4_next = 2'd1;
        else
            ax4_next = 2'd2;
        bbdep4_next = ov3_reg[ax4_next];
        bbpos4_next = dif3_reg[ax4_next] > 0;
    end

    always_comb
    begin
        logic [SW-1:0] s, sf;
        s  = sqv4_reg[0] + sqv4_reg[1] + sqv4_reg[2];
        sf = sqf4_reg[0] + sqf4_reg[1] + sqf4_reg[2];
        side5_next = '0;
        sq5_next   = '0;
        unique case (mode4_reg)
            MODE_BB:
            begin
                side5_next.hit = hitbb4_reg;
                side5_next.base = BW'(bbdep4_reg);
                side5_next.fn[ax4_reg] = bbpos4_reg ? NRM_POS : NRM_NEG;
            end
            MODE_SS:
            begin
                side5_next.hit = (rs4_reg > 0) && (s < SW'(rsq4_reg));
                side5_next.base = BW'(rs4_reg);
                if (s == '0)
                    side5_next.fn[0] = NRM_POS;
                else
                begin
                    side5_next.norm = 1'b1;
                    side5_next.sub_d = 1'b1;
                    for (int i = 0; i < 3; i++)
                        side5_next.v[i] = vv4_reg[i];
                    sq5_next = s;
                end
            end
            MODE_BS:
            begin
                side5_next.hit = (s <= SW'(rrq4_reg));
                side5_next.neg = swap4_reg;
                if (s > SW'(1))
                begin
                    side5_next.norm = 1'b1;
                    side5_next.sub_d = 1'b1;
                    side5_next.base = BW'(r4_reg);
                    for (int i = 0; i < 3; i++)
                        side5_next.v[i] = vv4_reg[i];
                    sq5_next = s;
                end
                else
                begin
                    side5_next.base = BW'(r4_reg) + BW'(mo4_reg);
                    if (sf > SW'(1))
                    begin
                        side5_next.norm = 1'b1;
                        for (int i = 0; i < 3; i++)
                            side5_next.v[i] = comp_t'(fc4_reg[i]);
                        sq5_next = sf;
                    end
                    else
                        side5_next.fn[1] = NRM_NEG;
                end
            end
            default:
            begin
                side5_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ka1_reg <= kind_a;
            kb1_reg <= kind_b;
            ca1_reg <= ca1_next;
            cb1_reg <= cb1_next;
            ea1_reg <= ea1_next;
            eb1_reg <= eb1_next;

            mode2_reg <= mode2_next;
            swap2_reg <= swap2_next;
            dif2_reg  <= dif2_next;
            hsum2_reg <= hsum2_next;
            lo2_reg   <= lo2_next;
            hi2_reg   <= hi2_next;
            sc2_reg   <= sc2_next;
            fc2_reg   <= fc2_next;
            r2_reg    <= r2_next;
            rs2_reg   <= rs2_next;

            mode3_reg <= mode2_reg;
            swap3_reg <= swap2_reg;
            ov3_reg   <= ov3_next;
            vv3_reg   <= vv3_next;
            ma3_reg   <= ma3_next;
            mb3_reg   <= mb3_next;
            dif3_reg  <= dif2_reg;
            fc3_reg   <= fc2_reg;
            r3_reg    <= r2_reg;
            rs3_reg   <= rs2_reg;
            rsq3_reg  <= rsq3_next;
            rrq3_reg  <= rrq3_next;

            mode4_reg   <= mode3_reg;
            swap4_reg   <= swap3_reg;
            sqv4_reg    <= sqv4_next;
            sqf4_reg    <= sqf4_next;
            mo4_reg     <= mo4_next;
            hitbb4_reg  <= hitbb4_next;
            ax4_reg     <= ax4_next;
            bbdep4_reg  <= bbdep4_next;
            bbpos4_reg  <= bbpos4_next;
            vv4_reg     <= vv3_reg;
            fc4_reg     <= fc3_reg;
            r4_reg      <= r3_reg;
            rs4_reg     <= rs3_reg;
            rsq4_reg    <= rsq3_reg;
            rrq4_reg    <= rrq3_reg;

            side5_reg <= side5_next;
            sq5_reg   <= sq5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_side  = side5_reg;
    assign out_sq    = sq5_reg;

endmodule

// File: sv/ncpt_sqrt.sv
`timescale 1ns / 1ps

module ncpt_sqrt import ncpt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  ncpt_side_t    in_side,
    input  logic [SW-1:0] in_sq,
    output logic          out_valid,
    output ncpt_side_t    out_side,
    output logic [RW-1:0] out_d
);

    logic          vld_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [RW+1:0] rem_reg  [RW];
    logic [SW-1:0] sq_reg   [RW];
    ncpt_side_t    side_reg [RW];

    logic          ovld_reg;
    ncpt_side_t    oside_reg;
    logic [RW-1:0] d_reg, d_next;

    for (genvar j = 0; j < RW; j++)
    begin : g_step
        localparam int K = RW - 1 - j;
        logic          pv;
        logic [RW-1:0] proot, root_next;
        logic [RW+1:0] prem, rem_next;
        logic [SW-1:0] psq;
        ncpt_side_t    pside;

        if (j == 0)
        begin : g_first
            assign pv    = in_valid;
            assign proot = '0;
            assign prem  = '0;
            assign psq   = in_sq;
            assign pside = in_side;
        end
        else
        begin : g_next
            assign pv    = vld_reg[j-1];
            assign proot = root_reg[j-1];
            assign prem  = rem_reg[j-1];
            assign psq   = sq_reg[j-1];
            assign pside = side_reg[j-1];
        end

        always_comb
        begin
            logic [RW+3:0] tmp, trial;
            tmp   = {prem, psq[2*K +: 2]};
            trial = (RW+4)'({proot, 2'b01});
            if (tmp >= trial)
            begin
                rem_next  = (RW+2)'(tmp - trial);
                root_next = {proot[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = (RW+2)'(tmp);
                root_next = {proot[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= pv;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[j] <= root_next;
                rem_reg[j]  <= rem_next;
                sq_reg[j]   <= psq;
                side_reg[j] <= pside;
            end
        end
    end

    // round half up: bump when remainder exceeds the floor root
    assign d_next = root_reg[RW-1] + RW'((RW+2)'(root_reg[RW-1]) < rem_reg[RW-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovld_reg <= 1'b0;
        else if (en)
            ovld_reg <= vld_reg[RW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg     <= d_next;
            oside_reg <= side_reg[RW-1];
        end
    end

    assign out_valid = ovld_reg;
    assign out_side  = oside_reg;
    assign out_d     = d_reg;

endmodule

// File: sv/ncpt_div.sv
`timescale 1ns / 1ps

module ncpt_div import ncpt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  ncpt_side_t    in_side,
    input  logic [RW-1:0] in_d,
    output logic          out_valid,
    output ncpt_side_t    out_side,
    output logic [RW-1:0] out_d,
    output logic [QB-1:0] out_q   [3],
    output logic          out_ovf [3]
);

    logic          vld_reg  [QB+1];
    ncpt_side_t    side_reg [QB+1];
    logic [RW-1:0] d_reg    [QB+1];
    logic [NW-1:0] rem_reg  [QB+1][3];
    logic [QB-1:0] q_reg    [QB+1][3];
    logic          ovf_reg  [QB+1][3];

    for (genvar j = 0; j <= QB; j++)
    begin : g_step
        logic          pv;
        ncpt_side_t    pside;
        logic [RW-1:0] pd;
        logic [NW-1:0] rem_next [3];
        logic [QB-1:0] q_next   [3];
        logic          ovf_next [3];

        if (j == 0)
        begin : g_prep
            assign pv    = in_valid;
            assign pside = in_side;
            assign pd    = in_d;
            always_comb
            begin
                logic [NW-1:0] n;
                for (int i = 0; i < 3; i++)
                begin
                    n = (NW'(abs_comp(comp_t'(in_side.v[i]))) << 14) + NW'(in_d >> 1);
                    rem_next[i] = n;
                    q_next[i]   = '0;
                    ovf_next[i] = n >= (NW'(in_d) << QB);
                end
            end
        end
        else
        begin : g_iter
            localparam int K = QB - j;
            assign pv    = vld_reg[j-1];
            assign pside = side_reg[j-1];
            assign pd    = d_reg[j-1];
            always_comb
            begin
                logic [NW-1:0] dk;
                dk = NW'(pd) << K;
                for (int i = 0; i < 3; i++)
                begin
                    rem_next[i] = rem_reg[j-1][i];
                    q_next[i]   = q_reg[j-1][i];
                    ovf_next[i] = ovf_reg[j-1][i];
                    if (rem_reg[j-1][i] >= dk)
                    begin
                        rem_next[i] = rem_reg[j-1][i] - dk;
                        q_next[i][K] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= pv;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j] <= pside;
                d_reg[j]    <= pd;
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= q_next;
                ovf_reg[j]  <= ovf_next;
            end
        end
    end

    assign out_valid = vld_reg[QB];
    assign out_side  = side_reg[QB];
    assign out_d     = d_reg[QB];
    assign out_q     = q_reg[QB];
    assign out_ovf   = ovf_reg[QB];

endmodule

// File: sv/narrow_phase_collision_test_core.sv
`timescale 1ns / 1ps

// channel | dir | payload
// s_*     | in  | collider pair: kinds in tuser, packed vectors in tdata
// m_*     | out | contact: hit, depth, normal x/y/z in tdata
//
// One request enters every cycle while the output is not stalled.
// The pipeline holds the 24-step square root and the 15-step normal divider.
// Reset clears the valid bits only.
// A stall on m_tready freezes every stage; s_tready follows it.

module narrow_phase_collision_test_core import ncpt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_a, offset_a, extent_a, pos_b, offset_b, extent_b, zero pad
    input  logic [383:0] s_tdata,
    // kind_a, kind_b
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit, depth, normal_x, normal_y, normal_z
    output logic [71:0]  m_tdata
);

    logic          en;
    logic          fv, sv_, dv;
    ncpt_side_t    fside, sside, dside;
    logic [SW-1:0] fsq;
    logic [RW-1:0] sd, dd;
    logic [QB-1:0] dq   [3];
    logic          dovf [3];

    logic          out_valid_reg;
    logic [71:0]   out_data_reg, out_data_next;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    ncpt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .kind_a   (s_tuser[0]),
        .kind_b   (s_tuser[1]),
        .pos_a    (s_tdata[PACK_W-1:0]),
        .offset_a (s_tdata[2*PACK_W-1:PACK_W]),
        .extent_a (s_tdata[3*PACK_W-1:2*PACK_W]),
        .pos_b    (s_tdata[4*PACK_W-1:3*PACK_W]),
        .offset_b (s_tdata[5*PACK_W-1:4*PACK_W]),
        .extent_b (s_tdata[6*PACK_W-1:5*PACK_W]),
        .out_valid(fv),
        .out_side (fside),
        .out_sq   (fsq)
    );

    ncpt_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (fv),
        .in_side  (fside),
        .in_sq    (fsq),
        .out_valid(sv_),
        .out_side (sside),
        .out_d    (sd)
    );

    ncpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sv_),
        .in_side  (sside),
        .in_d     (sd),
        .out_valid(dv),
        .out_side (dside),
        .out_d    (dd),
        .out_q    (dq),
        .out_ovf  (dovf)
    );

    always_comb
    begin
        logic [QB-1:0] mag;
        logic signed [NRM_W-1:0] n [3];
        logic signed [BW:0] dep;
        logic [DEPTH_W-1:0] depth;
        for (int i = 0; i < 3; i++)
        begin
            mag = (dovf[i] || dq[i] > ONE_Q14) ? ONE_Q14 : dq[i];
            if (dside.norm)
                n[i] = dside.v[i][VW-1] ? -NRM_W'(signed'({1'b0, mag}))
                                        : NRM_W'(signed'({1'b0, mag}));
            else
                n[i] = signed'(dside.fn[i]);
            if (dside.neg)
                n[i] = -n[i];
        end
        dep = (BW+1)'(dside.base) - (dside.sub_d ? (BW+1)'(signed'({1'b0, dd})) : '0);
        if (dep < 0)
            depth = '0;
        else if (dep > (BW+1)'(signed'({1'b0, DEPTH_MAX})))
            depth = DEPTH_MAX;
        else
            depth = DEPTH_W'(dep);
        if (dside.hit)
            out_data_next = {n[2], n[1], n[0], depth, 1'b1};
        else
            out_data_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: test/collision_checker.sv
`timescale 1ns / 1ps

module collision_checker import ncpt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [383:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic                hit;
        logic [DEPTH_W-1:0]  depth;
        logic [NRM_W-1:0]    nx;
        logic [NRM_W-1:0]    ny;
        logic [NRM_W-1:0]    nz;
    } contact_t;

    typedef longint vec_t[3];

    contact_t contact_q[$];

    function automatic longint coord_of(logic [63:0] packed_v, int idx);
        logic [CB-1:0] raw;
        raw = packed_v[idx*CB +: CB];
        return longint'($signed(raw));
    endfunction

    function automatic longint mag(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint lmin(longint a, longint b);
        return a < b ? a : b;
    endfunction

    function automatic longint lmax(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function automatic longint unsigned root_round(longint unsigned s);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (s >= r + bitv)
            begin
                s = s - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        if (s > r)
            r++;
        return r;
    endfunction

    function automatic longint unsigned sq_len(vec_t a);
        longint unsigned s;
        s = 0;
        for (int i = 0; i < 3; i++)
            s += longint'(mag(a[i])) * longint'(mag(a[i]));
        return s;
    endfunction

    function automatic void unit_vec(vec_t a, longint unsigned d, ref longint n[3]);
        longint unsigned m;
        longint unsigned q;
        for (int i = 0; i < 3; i++)
        begin
            m = longint'(mag(a[i])) * 16384;
            q = (m + d / 2) / d;
            if (q > 16384)
                q = 16384;
            n[i] = a[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void box_sphere_contact(vec_t ca, vec_t ha, vec_t sc, longint r,
                                               ref logic hit, ref longint depth,
                                               ref longint n[3]);
        vec_t dl;
        vec_t fc;
        longint lo[3];
        longint hi[3];
        longint mo;
        longint unsigned s;
        longint unsigned d;
        longint unsigned rr;
        for (int i = 0; i < 3; i++)
        begin
            lo[i] = ca[i] - ha[i];
            hi[i] = ca[i] + ha[i];
            dl[i] = sc[i] - lmax(lo[i], lmin(sc[i], hi[i]));
        end
        s = sq_len(dl);
        rr = longint'(mag(r)) * longint'(mag(r));
        if (s > rr)
            return;
        hit = 1'b1;
        if (s > 1)
        begin
            d = root_round(s);
            unit_vec(dl, d, n);
            depth = r - longint'(d);
        end
        else
        begin
            mo = sc[0] - lo[0];
            for (int i = 0; i < 3; i++)
            begin
                mo = lmin(mo, sc[i] - lo[i]);
                mo = lmin(mo, hi[i] - sc[i]);
                fc[i] = sc[i] - ca[i];
            end
            s = sq_len(fc);
            if (s > 1)
                unit_vec(fc, root_round(s), n);
            else
                n[1] = -16384;
            depth = r + mo;
        end
    endfunction

    function automatic contact_t predict_contact(logic [383:0] payload, logic [1:0] kinds);
        vec_t ca;
        vec_t cb;
        vec_t ea;
        vec_t eb;
        vec_t dif;
        longint ov[3];
        longint n[3];
        longint depth;
        longint rs;
        longint unsigned s;
        longint unsigned d;
        logic hit;
        int ax;
        contact_t c;
        hit = 1'b0;
        depth = 0;
        n = '{0, 0, 0};
        for (int i = 0; i < 3; i++)
        begin
            ca[i] = coord_of(payload[0 +: 64], i) + coord_of(payload[63 +: 64], i);
            ea[i] = coord_of(payload[126 +: 64], i);
            cb[i] = coord_of(payload[189 +: 64], i) + coord_of(payload[252 +: 64], i);
            eb[i] = coord_of(payload[315 +: 64], i);
        end
        if (kinds == 2'b00)
        begin
            hit = 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                dif[i] = cb[i] - ca[i];
                ov[i] = (ea[i] + eb[i]) - mag(dif[i]);
                if (ov[i] <= 0)
                    hit = 1'b0;
            end
            if (hit)
            begin
                if (ov[0] < ov[1] && ov[0] < ov[2])
                    ax = 0;
                else if (ov[1] < ov[2])
                    ax = 1;
                else
                    ax = 2;
                depth = ov[ax];
                n[ax] = dif[ax] > 0 ? 16384 : -16384;
            end
        end
        else if (kinds == 2'b11)
        begin
            rs = ea[0] + eb[0];
            for (int i = 0; i < 3; i++)
                dif[i] = cb[i] - ca[i];
            s = sq_len(dif);
            if (rs > 0 && s < longint'(rs) * longint'(rs))
            begin
                hit = 1'b1;
                if (s == 0)
                begin
                    n[0] = 16384;
                    depth = rs;
                end
                else
                begin
                    d = root_round(s);
                    unit_vec(dif, d, n);
                    depth = rs - longint'(d);
                end
            end
        end
        else if (kinds == 2'b10)
            box_sphere_contact(ca, ea, cb, eb[0], hit, depth, n);
        else
        begin
            box_sphere_contact(cb, eb, ca, ea[0], hit, depth, n);
            for (int i = 0; i < 3; i++)
                n[i] = -n[i];
        end
        if (!hit)
        begin
            depth = 0;
            n = '{0, 0, 0};
        end
        if (depth < 0)
            depth = 0;
        if (depth > 8388607)
            depth = 8388607;
        c.hit = hit;
        c.depth = depth[DEPTH_W-1:0];
        c.nx = n[0][15:0];
        c.ny = n[1][15:0];
        c.nz = n[2][15:0];
        return c;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        contact_t exp_c;
        contact_t got;
        if (!rst_n)
        begin
            fail_count <= 0;
            contact_q.delete();
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                contact_q.push_back(predict_contact(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
            begin
                got.hit = m_tdata[0];
                got.depth = m_tdata[23:1];
                got.nx = m_tdata[39:24];
                got.ny = m_tdata[55:40];
                got.nz = m_tdata[71:56];
                if (contact_q.size() == 0)
                begin
                    $error("contact with no request pending");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_c = contact_q.pop_front();
                    if (got.hit !== exp_c.hit)
                        $error("hit exp %0d got %0d", exp_c.hit, got.hit);
                    if (got.depth !== exp_c.depth)
                        $error("depth exp %0d got %0d", exp_c.depth, got.depth);
                    if (got.nx !== exp_c.nx)
                        $error("normal_x exp %0d got %0d", $signed(exp_c.nx), $signed(got.nx));
                    if (got.ny !== exp_c.ny)
                        $error("normal_y exp %0d got %0d", $signed(exp_c.ny), $signed(got.ny));
                    if (got.nz !== exp_c.nz)
                        $error("normal_z exp %0d got %0d", $signed(exp_c.nz), $signed(got.nz));
                    if (got !== exp_c)
                        fail_count <= fail_count + 1;
                end
            end
            pending <= contact_q.size();
        end
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench import ncpt_pkg::*;;

    localparam int WATCHDOG = 5000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [383:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    int           fail_count;
    int           pending;
    int           idle_cycles = 0;
    bit           stall_mode = 1'b0;

    narrow_phase_collision_test_core u_top (.*);

    collision_checker u_checker (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: alternate free-flowing stretches and random stalls
    always @(posedge clk)
    begin
        if ($urandom_range(0, 99) == 0)
            stall_mode <= ~stall_mode;
        m_tready <= stall_mode ? ($urandom_range(0, 3) != 0 ? 1'b0 : 1'b1)
                               : ($urandom_range(0, 9) != 0);
    end

    function automatic logic [20:0] rand_coord(int sel);
        case (sel)
            0: return 21'h0FFFFF;
            1: return 21'h100000;
            2: return 21'h000000;
            3: return 21'h1FFFFF;
            default: return 21'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    function automatic logic [62:0] vec3_of(logic [20:0] x, logic [20:0] y, logic [20:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [62:0] rand_raw();
        return 63'({$urandom, $urandom});
    endfunction

    function automatic logic [62:0] rand_vec(int spread, bit allow_neg);
        logic [20:0] c[3];
        for (int i = 0; i < 3; i++)
        begin
            if (allow_neg)
                c[i] = 21'($signed($urandom_range(0, 2 * spread)) - spread);
            else
                c[i] = 21'($urandom_range(0, spread));
        end
        return vec3_of(c[0], c[1], c[2]);
    endfunction

    task automatic send_pair(logic [1:0] kinds, logic [62:0] pa, logic [62:0] oa,
                             logic [62:0] ea, logic [62:0] pb, logic [62:0] ob,
                             logic [62:0] eb);
        s_tvalid <= 1'b1;
        s_tuser <= kinds;
        s_tdata <= {6'd0, eb, ob, pb, ea, oa, pa};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic pause_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_random();
        logic [1:0] kinds;
        int spread;
        kinds = 2'($urandom_range(0, 3));
        spread = ($urandom_range(0, 9) == 0) ? 1048575 : 3000;
        if ($urandom_range(0, 19) == 0)
            send_pair(kinds, rand_raw(), rand_raw(), rand_raw(),
                      rand_raw(), rand_raw(), rand_raw());
        else
            send_pair(kinds, rand_vec(spread, 1'b1), rand_vec(200, 1'b1),
                      rand_vec(2000, $urandom_range(0, 9) == 0),
                      rand_vec(spread, 1'b1), rand_vec(200, 1'b1),
                      rand_vec(2000, $urandom_range(0, 9) == 0));
    endtask

    initial
    begin
        logic [62:0] zero;
        logic [62:0] one;
        int burst;
        zero = '0;
        one = vec3_of(21'd256, 21'd256, 21'd256);
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 2'b00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // box-box ties and misses
        send_pair(2'b00, zero, zero, one, vec3_of(21'd100, 21'd100, 21'd100), zero, one);
        send_pair(2'b00, zero, zero, one, vec3_of(21'd100, 21'd50, 21'd100), zero, one);
        send_pair(2'b00, zero, zero, one, vec3_of(-21'd10, -21'd20, -21'd30), zero, one);
        send_pair(2'b00, zero, zero, one, vec3_of(21'd600, 21'd0, 21'd0), zero, one);
        send_pair(2'b00, zero, zero, one, zero, zero, one);
        // sphere-sphere: coincident, touching, overlap, negative radius
        send_pair(2'b11, zero, zero, one, zero, zero, one);
        send_pair(2'b11, zero, zero, one, vec3_of(21'd512, 21'd0, 21'd0), zero, one);
        send_pair(2'b11, zero, zero, one, vec3_of(21'd100, -21'd77, 21'd33), zero, one);
        send_pair(2'b11, zero, zero, vec3_of(-21'd256, 21'd0, 21'd0), zero, zero,
                  vec3_of(-21'd256, 21'd0, 21'd0));
        // box-sphere: outside, surface, inside, centered, sphere-box
        send_pair(2'b10, zero, zero, one, vec3_of(21'd400, 21'd300, 21'd0), zero, one);
        send_pair(2'b10, zero, zero, one, vec3_of(21'd257, 21'd0, 21'd0), zero, one);
        send_pair(2'b10, zero, zero, one, vec3_of(21'd10, 21'd20, 21'd0), zero, one);
        send_pair(2'b10, zero, zero, one, zero, zero, one);
        send_pair(2'b10, zero, zero, one, vec3_of(21'd1, 21'd0, 21'd0), zero, one);
        send_pair(2'b01, vec3_of(21'd400, 21'd0, 21'd0), zero, one, zero, zero, one);
        send_pair(2'b01, zero, zero, one, zero, zero, one);
        send_pair(2'b10, zero, zero, vec3_of(21'd256, -21'd256, 21'd256),
                  vec3_of(21'd50, 21'd0, 21'd0), zero, vec3_of(-21'd300, 21'd0, 21'd0));
        // coordinate extremes and saturation
        for (int k = 0; k < 4; k++)
            send_pair(2'(k), vec3_of(rand_coord(0), rand_coord(1), rand_coord(3)),
                      vec3_of(rand_coord(0), rand_coord(0), rand_coord(0)),
                      vec3_of(rand_coord(0), rand_coord(0), rand_coord(0)),
                      vec3_of(rand_coord(1), rand_coord(1), rand_coord(1)),
                      vec3_of(rand_coord(1), rand_coord(2), rand_coord(1)),
                      vec3_of(rand_coord(0), rand_coord(0), rand_coord(0)));
        send_pair(2'b11, {63{1'b1}}, {63{1'b1}}, {63{1'b1}}, {63{1'b1}}, {63{1'b1}},
                  {63{1'b1}});

        // hold until drained
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || (s_tvalid && !s_tready))
            @(posedge clk);

        for (int n = 0; n < 700; )
        begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < 700; b++, n++)
                send_random();
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 8));
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: narrow_phase_collision_test_core.f
sv/ncpt_pkg.sv
sv/ncpt_front.sv
sv/ncpt_sqrt.sv
sv/ncpt_div.sv
sv/narrow_phase_collision_test_core.sv
test/collision_checker.sv
test/testbench.sv
